FILE: rtl/core/keyed_flag_table_assert.svh
// ----------------------------------------------------------------------------
// keyed_flag_table assertion macros
// Concurrent checks clocked by clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef KEYED_FLAG_TABLE_ASSERT_SVH
`define KEYED_FLAG_TABLE_ASSERT_SVH

`ifndef SYNTH
// Property holds at every clock edge outside reset.
`define KFT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Consequent holds in the cycle after the antecedent.
`define KFT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define KFT_ASSERT(lbl, prop, msg)
`define KFT_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

FILE: rtl/core/kft_pkg.sv
// ----------------------------------------------------------------------------
// kft_pkg
// Shared widths, command codes and the decoded command type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package kft_pkg;

  localparam int unsigned KFT_MAX_ENTRIES = 32;
  localparam int unsigned KFT_QUEUE_DEPTH = 2;

  localparam int unsigned CMD_W   = 2;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned KEY_W   = 2 * BYTE_W;
  localparam int unsigned PARAM_W = 16;
  localparam int unsigned ENTRY_W = KEY_W + PARAM_W;
  localparam int unsigned COUNT_W = 6;

  typedef enum logic [CMD_W-1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_GET    = 2'd2,
    OP_HAS    = 2'd3
  } op_e;

  // Decoded command as it travels from the front end to the back end
  typedef struct packed {
    op_e                op;
    logic               search;
    logic [KEY_W-1:0]   key;
    logic [PARAM_W-1:0] param;
  } cmd_t;

endpackage

FILE: rtl/core/kft_if.sv
// ----------------------------------------------------------------------------
// kft channel interfaces
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface kft_in_if;
  logic                         valid;
  logic                         ready;
  logic [kft_pkg::CMD_W-1:0]    cmd;
  logic [kft_pkg::BYTE_W-1:0]   game;
  logic [kft_pkg::BYTE_W-1:0]   flag;
  logic [kft_pkg::PARAM_W-1:0]  param_in;

  modport source (output valid, cmd, game, flag, param_in, input ready);
  modport sink   (input valid, cmd, game, flag, param_in, output ready);
endinterface

interface kft_out_if;
  logic                         valid;
  logic                         ready;
  logic                         ok;
  logic [kft_pkg::PARAM_W-1:0]  param_out;
  logic [kft_pkg::COUNT_W-1:0]  entry_count;

  modport source (output valid, ok, param_out, entry_count, input ready);
  modport sink   (input valid, ok, param_out, entry_count, output ready);
endinterface

FILE: rtl/core/kft_ram.sv
// ----------------------------------------------------------------------------
// kft_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kft_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/kft_front.sv
// ----------------------------------------------------------------------------
// kft_front
// Input stage: takes command items, decodes them and holds one decoded item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kft_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  kft_in_if.sink        in_i,
  output logic          cmd_valid_o,
  input  logic          cmd_ready_i,
  output kft_pkg::cmd_t cmd_o
);

  logic          stg_valid_q, stg_valid_d;
  kft_pkg::cmd_t stg_q, stg_d;
  kft_pkg::op_e  op;

  // Stage frees up whenever its item moves on
  assign in_i.ready = !stg_valid_q || cmd_ready_i;

  // Decode: key is game in the high byte, flag in the low byte
  always_comb begin
    op           = kft_pkg::op_e'(in_i.cmd);
    stg_d.op     = op;
    stg_d.search = (op != kft_pkg::OP_ADD);
    stg_d.key    = {in_i.game, in_i.flag};
    stg_d.param  = in_i.param_in;
  end

  always_comb begin
    stg_valid_d = stg_valid_q;
    if (in_i.ready) begin
      stg_valid_d = in_i.valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
    end else begin
      stg_valid_q <= stg_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      stg_q <= stg_d;
    end
  end

  assign cmd_valid_o = stg_valid_q;
  assign cmd_o       = stg_q;

endmodule

FILE: rtl/core/kft_queue.sv
// ----------------------------------------------------------------------------
// kft_queue
// Short FIFO of decoded commands between the front end and the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kft_queue #(
  parameter int unsigned Depth = kft_pkg::KFT_QUEUE_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  kft_pkg::cmd_t push_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output kft_pkg::cmd_t pop_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned FillW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [FillW-1:0] Full = FillW'(Depth);

  kft_pkg::cmd_t    mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic             push, pop;

  assign push_ready_o = (fill_q != Full);
  assign pop_valid_o  = (fill_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_o        = mem_q[rd_ptr_q];

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      fill_d = fill_q + 1'b1;
    end else if (pop && !push) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_i;
    end
  end

endmodule

FILE: rtl/core/kft_back.sv
// ----------------------------------------------------------------------------
// kft_back
// Executes commands against the entry RAM: append, scan, shift-down removal.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "keyed_flag_table_assert.svh"

module kft_back #(
  parameter int unsigned MAX_ENTRIES = kft_pkg::KFT_MAX_ENTRIES
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  output logic          cmd_ready_o,
  input  kft_pkg::cmd_t cmd_i,
  kft_out_if.source     out_o
);

  localparam int unsigned IdxW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CntW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned KeyW = kft_pkg::KEY_W;
  localparam int unsigned ParamW = kft_pkg::PARAM_W;
  localparam int unsigned EntryW = kft_pkg::ENTRY_W;
  localparam int unsigned OutCntW = kft_pkg::COUNT_W;
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_ENTRIES);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [CntW-1:0]   iss_q, iss_d;      // next RAM index to read
  logic              chk_q, chk_d;      // read data valid this cycle
  logic [IdxW-1:0]   chk_idx_q, chk_idx_d;
  kft_pkg::op_e      op_q;
  logic [KeyW-1:0]   key_q;

  logic              res_valid_q, res_valid_d;
  logic              res_ok_q, res_ok_d;
  logic [ParamW-1:0] res_param_q, res_param_d;
  logic [CntW-1:0]   res_cnt_q;
  logic              res_load;
  logic              pop;

  logic              ram_we, ram_re;
  logic [IdxW-1:0]   ram_waddr, ram_raddr;
  logic [EntryW-1:0] ram_wdata, ram_rdata;
  logic              hit;

  kft_ram #(
    .Width (EntryW),
    .Depth (MAX_ENTRIES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Take a command only when idle and the result register is empty
  assign cmd_ready_o = (state_q == S_IDLE) && !res_valid_q;
  assign hit         = chk_q && (ram_rdata[KeyW-1:0] == key_q);

  // Command sequencer
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    iss_d       = iss_q;
    chk_d       = 1'b0;
    chk_idx_d   = chk_idx_q;
    ram_we      = 1'b0;
    ram_waddr   = cnt_q[IdxW-1:0];
    ram_wdata   = {cmd_i.param, cmd_i.key};
    ram_re      = 1'b0;
    ram_raddr   = iss_q[IdxW-1:0];
    res_load    = 1'b0;
    res_ok_d    = 1'b0;
    res_param_d = '0;
    pop         = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_valid_i && cmd_ready_o) begin
          pop = 1'b1;
          if (!cmd_i.search) begin
            // Append at the tail unless full
            res_load = 1'b1;
            if (cnt_q < CntMax) begin
              ram_we   = 1'b1;
              cnt_d    = cnt_q + 1'b1;
              res_ok_d = 1'b1;
            end
          end else if (cnt_q == '0) begin
            res_load = 1'b1;
          end else begin
            iss_d   = '0;
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (hit) begin
          if (op_q == kft_pkg::OP_REMOVE) begin
            iss_d   = CntW'(chk_idx_q) + 1'b1;
            state_d = S_SHIFT;
          end else begin
            res_load = 1'b1;
            res_ok_d = 1'b1;
            if (op_q == kft_pkg::OP_GET) begin
              res_param_d = ram_rdata[EntryW-1:KeyW];
            end
            state_d = S_IDLE;
          end
        end else if (!chk_q && (iss_q >= cnt_q)) begin
          // Every entry checked, no match
          res_load = 1'b1;
          state_d  = S_IDLE;
        end else if (iss_q < cnt_q) begin
          ram_re    = 1'b1;
          chk_d     = 1'b1;
          chk_idx_d = iss_q[IdxW-1:0];
          iss_d     = iss_q + 1'b1;
        end
      end
      S_SHIFT: begin
        // Write back the entry read last cycle one place lower
        if (chk_q) begin
          ram_we    = 1'b1;
          ram_waddr = chk_idx_q;
          ram_wdata = ram_rdata;
        end
        if (iss_q < cnt_q) begin
          ram_re    = 1'b1;
          chk_d     = 1'b1;
          chk_idx_d = IdxW'(iss_q - 1'b1);
          iss_d     = iss_q + 1'b1;
        end else if (!chk_q) begin
          cnt_d    = cnt_q - 1'b1;
          res_load = 1'b1;
          res_ok_d = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Result register valid
  always_comb begin
    res_valid_d = res_valid_q;
    if (res_load) begin
      res_valid_d = 1'b1;
    end else if (out_o.ready) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      chk_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      chk_q       <= chk_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    iss_q     <= iss_d;
    chk_idx_q <= chk_idx_d;
    if (pop) begin
      op_q  <= cmd_i.op;
      key_q <= cmd_i.key;
    end
    if (res_load) begin
      res_ok_q    <= res_ok_d;
      res_param_q <= res_param_d;
      res_cnt_q   <= cnt_d;
    end
  end

  assign out_o.valid       = res_valid_q;
  assign out_o.ok          = res_ok_q;
  assign out_o.param_out   = res_param_q;
  assign out_o.entry_count = OutCntW'(res_cnt_q);

  // Checks
  `KFT_ASSERT(a_cnt_bound, cnt_q <= CntMax, "entry count above capacity")
  `KFT_ASSERT(a_scan_no_write, (state_q == S_SCAN) |-> !ram_we, "RAM written during scan")
  `KFT_ASSERT(a_res_free, res_load |-> !res_valid_q, "pending result overwritten")
  `KFT_ASSERT_NEXT(a_cnt_hold, !res_load, $stable(cnt_q), "count moved without a result")
  `KFT_ASSERT(a_shift_ports, (ram_we && ram_re) |-> (ram_waddr != ram_raddr), "shift port clash")

endmodule

FILE: rtl/core/keyed_flag_table.sv
// ----------------------------------------------------------------------------
// keyed_flag_table
// Ordered key/parameter list searched by content: add, remove, get, contains.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Each command item yields exactly one result item carrying ok, the parameter
// found by a get, and the entry count after the command. Entries live in a
// single-port-write, registered-read RAM that is scanned one entry per cycle
// from index 0. An add writes at the tail straight from idle; get and contains
// scan until the first match or past the last entry (an empty list answers
// without a scan); a remove scans for its entry, then moves the later entries
// down one place, none when it is the last entry. A front stage and a short
// command queue keep taking items while the back end works or a result waits
// to be taken. No clearing pass runs after reset: entries are only read below
// the current count.
module keyed_flag_table #(
  parameter int unsigned MAX_ENTRIES = kft_pkg::KFT_MAX_ENTRIES,
  parameter int unsigned QUEUE_DEPTH = kft_pkg::KFT_QUEUE_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  kft_in_if.sink    in_i,
  kft_out_if.source out_o
);

  logic          fe_valid, fe_ready;
  kft_pkg::cmd_t fe_cmd;
  logic          be_valid, be_ready;
  kft_pkg::cmd_t be_cmd;

  kft_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_valid_o (fe_valid),
    .cmd_ready_i (fe_ready),
    .cmd_o       (fe_cmd)
  );

  kft_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fe_valid),
    .push_ready_o (fe_ready),
    .push_i       (fe_cmd),
    .pop_valid_o  (be_valid),
    .pop_ready_i  (be_ready),
    .pop_o        (be_cmd)
  );

  kft_back #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (be_valid),
    .cmd_ready_o (be_ready),
    .cmd_i       (be_cmd),
    .out_o       (out_o)
  );

endmodule
